// File: rtl/chm_pkg.sv
// Shared types and constants of the chained hash map.
// Holds table sizes, field widths, command and result codes, the datapath
// operation codes and the controller state type. No dependencies.
package chm_pkg;

	// Table sizes (bucket and node pools are the same size)
	localparam int NUM_BUCKETS = 1024;
	localparam int NUM_NODES   = 1024;
	localparam int VALUE_BITS  = 64;
	localparam int KEY_BITS    = 31;
	localparam int CMD_BITS    = 2;
	localparam int STAT_BITS   = 2;
	localparam int BC_BITS     = 11;

	localparam int BKT_AW    = $clog2(NUM_BUCKETS);
	localparam int NODE_AW   = $clog2(NUM_NODES);
	localparam int LINK_BITS = $clog2(NUM_NODES + 1);
	localparam int CNT_BITS  = $clog2(NUM_NODES + 1);
	localparam int DIV_W     = $clog2(NUM_BUCKETS + 1);

	// Remainder unit: four quotient bits per cycle
	localparam int DIGIT_BITS = 4;
	localparam int DIV_ITERS  = (KEY_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
	localparam int NUM_W      = DIV_ITERS * DIGIT_BITS;
	localparam int ITER_BITS  = $clog2(DIV_ITERS);

	// Stream payload widths
	localparam int S_DATA_W = ((KEY_BITS + VALUE_BITS + 7) / 8) * 8;
	localparam int M_DATA_W = ((VALUE_BITS + 7) / 8) * 8;

	localparam logic [LINK_BITS-1:0] NULL_LINK = LINK_BITS'(NUM_NODES);

	typedef enum logic [CMD_BITS-1:0] {
		CMD_INSERT = 2'd0,
		CMD_FIND   = 2'd1,
		CMD_ERASE  = 2'd2
	} cmd_t;

	typedef enum logic [STAT_BITS-1:0] {
		RES_NEW  = 2'd0,
		RES_HIT  = 2'd1,
		RES_MISS = 2'd2,
		RES_FULL = 2'd3
	} res_t;

	// One datapath operation per cycle, chosen by the controller
	typedef enum logic [3:0] {
		OP_NONE,
		OP_CLEAR,
		OP_LOAD,
		OP_HEAD_CAP,
		OP_NODE_STEP,
		OP_NODE_HIT,
		OP_UPDATE,
		OP_FULL,
		OP_POP_RD,
		OP_LINK_NEW,
		OP_FIND,
		OP_ERASE,
		OP_MISS,
		OP_EMIT
	} dp_op_t;

	// Status from datapath to controller
	typedef struct packed {
		logic                clear_last;
		logic                rem_done;
		logic                chain_end;
		logic                key_match;
		logic                found;
		logic                full;
		logic                out_free;
		logic [CMD_BITS-1:0] command;
	} dp_stat_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIV,
		ST_HEAD_RD,
		ST_HEAD_CAP,
		ST_CHECK,
		ST_NODE,
		ST_ACT,
		ST_POP,
		ST_RESULT
	} state_t;

endpackage

// File: rtl/chm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module chm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/chm_rem.sv
// Iterative remainder unit: key modulo bucket count, four bits per cycle.
// Depends on chm_pkg.
module chm_rem (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [chm_pkg::KEY_BITS-1:0] num,
	input  logic [chm_pkg::DIV_W-1:0]    divisor,
	output logic                         done,
	output logic [chm_pkg::BKT_AW-1:0]   rem
);
	import chm_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [ITER_BITS-1:0] iter_q;
	logic [NUM_W-1:0]     num_q;
	logic [DIV_W-1:0]     div_q;
	logic [DIV_W-1:0]     rem_q;
	logic [DIV_W-1:0]     rem_next;

	// Four restoring steps on the partial remainder
	always_comb begin
		logic [DIV_W:0] trial;
		rem_next = rem_q;
		for (int i = 0; i < DIGIT_BITS; i++) begin
			trial = {rem_next, num_q[NUM_W-1-i]};
			if (trial >= {1'b0, div_q}) begin
				trial = trial - {1'b0, div_q};
			end
			rem_next = trial[DIV_W-1:0];
		end
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			iter_q <= '0;
		end else if (busy_q) begin
			iter_q <= iter_q + 1'b1;
			if (iter_q == ITER_BITS'(DIV_ITERS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// Operands and partial remainder
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= NUM_W'(num);
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= num_q << DIGIT_BITS;
			rem_q <= rem_next;
		end
	end

	assign done = done_q;
	assign rem  = rem_q[BKT_AW-1:0];

endmodule

// File: rtl/chm_datapath.sv
// Datapath of the chained hash map: memories, chain walk registers, remainder
// unit, free stack pointer and result register. Depends on chm_pkg, chm_ram
// and chm_rem.
module chm_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  chm_pkg::dp_op_t               op,
	output chm_pkg::dp_stat_t             stat,
	input  logic [chm_pkg::S_DATA_W-1:0]  s_tdata,
	input  logic [chm_pkg::CMD_BITS-1:0]  s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [chm_pkg::M_DATA_W-1:0]  m_tdata,
	output logic [chm_pkg::STAT_BITS-1:0] m_tuser,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [chm_pkg::BC_BITS-1:0]   cfg_data
);
	import chm_pkg::*;

	// Configuration and command registers
	logic [BC_BITS-1:0]    nbkt_q;
	logic [CMD_BITS-1:0]   cmd_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] val_q;

	// Walk state
	logic [LINK_BITS-1:0]  cur_q;
	logic [LINK_BITS-1:0]  prev_q;
	logic [LINK_BITS-1:0]  head_q;
	logic [CNT_BITS-1:0]   steps_q;
	logic                  found_q;
	logic [NODE_AW-1:0]    hit_q;
	logic [LINK_BITS-1:0]  hit_link_q;
	logic [VALUE_BITS-1:0] hit_val_q;
	logic [CNT_BITS-1:0]   free_count_q;
	logic [BKT_AW-1:0]     clr_q;

	// Result
	logic [STAT_BITS-1:0]  res_status_q;
	logic [VALUE_BITS-1:0] res_value_q;
	logic                  out_valid_q;
	logic [STAT_BITS-1:0]  out_status_q;
	logic [VALUE_BITS-1:0] out_value_q;

	logic                  rem_done;
	logic [BKT_AW-1:0]     bucket;
	logic [DIV_W-1:0]      eff_div;

	logic                  head_we;
	logic [BKT_AW-1:0]     head_waddr;
	logic [LINK_BITS-1:0]  head_wdata;
	logic [LINK_BITS-1:0]  head_rdata;
	logic                  stk_we;
	logic [NODE_AW-1:0]    stk_waddr;
	logic [NODE_AW-1:0]    stk_wdata;
	logic [NODE_AW-1:0]    stk_rdata;
	logic                  key_we;
	logic [KEY_BITS-1:0]   key_rdata;
	logic                  val_we;
	logic [NODE_AW-1:0]    val_waddr;
	logic [VALUE_BITS-1:0] val_rdata;
	logic                  link_we;
	logic [NODE_AW-1:0]    link_waddr;
	logic [LINK_BITS-1:0]  link_wdata;
	logic [LINK_BITS-1:0]  link_rdata;
	logic                  prev_null;
	logic                  out_free;

	assign cfg_ready = 1'b1;
	assign prev_null = (prev_q == NULL_LINK);
	assign out_free  = !out_valid_q || m_tready;

	// Bucket count clamped to 1..NUM_BUCKETS
	always_comb begin
		if (nbkt_q == '0) begin
			eff_div = DIV_W'(1);
		end else if (DIV_W'(nbkt_q) > DIV_W'(NUM_BUCKETS)) begin
			eff_div = DIV_W'(NUM_BUCKETS);
		end else begin
			eff_div = DIV_W'(nbkt_q);
		end
	end

	chm_rem u_rem (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (op == OP_LOAD),
		.num     (s_tdata[KEY_BITS-1:0]),
		.divisor (eff_div),
		.done    (rem_done),
		.rem     (bucket)
	);

	// Memory write steering
	always_comb begin
		head_we    = 1'b0;
		head_waddr = bucket;
		head_wdata = NULL_LINK;
		stk_we     = 1'b0;
		stk_waddr  = free_count_q[NODE_AW-1:0];
		stk_wdata  = hit_q;
		key_we     = 1'b0;
		val_we     = 1'b0;
		val_waddr  = stk_rdata;
		link_we    = 1'b0;
		link_waddr = stk_rdata;
		link_wdata = head_q;
		case (op)
			OP_CLEAR: begin
				head_we    = 1'b1;
				head_waddr = clr_q;
				stk_we     = 1'b1;
				stk_waddr  = NODE_AW'(clr_q);
				stk_wdata  = NODE_AW'(NUM_NODES - 1) - NODE_AW'(clr_q);
			end
			OP_LINK_NEW: begin
				head_we    = 1'b1;
				head_wdata = LINK_BITS'(stk_rdata);
				key_we     = 1'b1;
				val_we     = 1'b1;
				link_we    = 1'b1;
			end
			OP_UPDATE: begin
				val_we    = 1'b1;
				val_waddr = hit_q;
			end
			OP_ERASE: begin
				head_we    = prev_null;
				head_wdata = hit_link_q;
				link_we    = !prev_null;
				link_waddr = prev_q[NODE_AW-1:0];
				link_wdata = hit_link_q;
				stk_we     = (free_count_q < CNT_BITS'(NUM_NODES));
			end
			default: begin
			end
		endcase
	end

	chm_ram #(.WIDTH(LINK_BITS), .DEPTH(NUM_BUCKETS)) u_head (
		.clk   (clk),
		.we    (head_we),
		.waddr (head_waddr),
		.wdata (head_wdata),
		.raddr (bucket),
		.rdata (head_rdata)
	);

	chm_ram #(.WIDTH(NODE_AW), .DEPTH(NUM_NODES)) u_free_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.raddr (free_count_q[NODE_AW-1:0] - 1'b1),
		.rdata (stk_rdata)
	);

	chm_ram #(.WIDTH(KEY_BITS), .DEPTH(NUM_NODES)) u_node_key (
		.clk   (clk),
		.we    (key_we),
		.waddr (stk_rdata),
		.wdata (key_q),
		.raddr (cur_q[NODE_AW-1:0]),
		.rdata (key_rdata)
	);

	chm_ram #(.WIDTH(VALUE_BITS), .DEPTH(NUM_NODES)) u_node_value (
		.clk   (clk),
		.we    (val_we),
		.waddr (val_waddr),
		.wdata (val_q),
		.raddr (cur_q[NODE_AW-1:0]),
		.rdata (val_rdata)
	);

	chm_ram #(.WIDTH(LINK_BITS), .DEPTH(NUM_NODES)) u_node_link (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.raddr (cur_q[NODE_AW-1:0]),
		.rdata (link_rdata)
	);

	// Control registers: config, clear sweep, free count, found flag, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nbkt_q       <= BC_BITS'(1024);
			clr_q        <= '0;
			free_count_q <= CNT_BITS'(NUM_NODES);
			out_valid_q  <= 1'b0;
			found_q      <= 1'b0;
		end else begin
			if (cfg_valid) begin
				nbkt_q <= cfg_data;
			end
			if (op == OP_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (op == OP_POP_RD) begin
				free_count_q <= free_count_q - 1'b1;
			end else if (op == OP_ERASE && free_count_q < CNT_BITS'(NUM_NODES)) begin
				free_count_q <= free_count_q + 1'b1;
			end
			if (op == OP_HEAD_CAP) begin
				found_q <= 1'b0;
			end else if (op == OP_NODE_HIT) begin
				found_q <= 1'b1;
			end
			if (op == OP_EMIT) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		case (op)
			OP_LOAD: begin
				cmd_q <= s_tuser;
				key_q <= s_tdata[KEY_BITS-1:0];
				val_q <= s_tdata[KEY_BITS+VALUE_BITS-1:KEY_BITS];
			end
			OP_HEAD_CAP: begin
				cur_q   <= head_rdata;
				head_q  <= head_rdata;
				prev_q  <= NULL_LINK;
				steps_q <= '0;
			end
			OP_NODE_STEP: begin
				prev_q  <= cur_q;
				cur_q   <= link_rdata;
				steps_q <= steps_q + 1'b1;
			end
			OP_NODE_HIT: begin
				hit_q      <= cur_q[NODE_AW-1:0];
				hit_link_q <= link_rdata;
				hit_val_q  <= val_rdata;
			end
			OP_UPDATE, OP_ERASE: begin
				res_status_q <= RES_HIT;
				res_value_q  <= '0;
			end
			OP_FIND: begin
				res_status_q <= RES_HIT;
				res_value_q  <= hit_val_q;
			end
			OP_FULL: begin
				res_status_q <= RES_FULL;
				res_value_q  <= '0;
			end
			OP_LINK_NEW: begin
				res_status_q <= RES_NEW;
				res_value_q  <= '0;
			end
			OP_MISS: begin
				res_status_q <= RES_MISS;
				res_value_q  <= '0;
			end
			OP_EMIT: begin
				out_status_q <= res_status_q;
				out_value_q  <= res_value_q;
			end
			default: begin
			end
		endcase
	end

	// Status to the controller
	assign stat.clear_last = (clr_q == BKT_AW'(NUM_BUCKETS - 1));
	assign stat.rem_done   = rem_done;
	assign stat.chain_end  = (cur_q == NULL_LINK) || (steps_q == CNT_BITS'(NUM_NODES));
	assign stat.key_match  = (key_rdata == key_q);
	assign stat.found      = found_q;
	assign stat.full       = (free_count_q == '0);
	assign stat.out_free   = out_free;
	assign stat.command    = cmd_q;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = M_DATA_W'(out_value_q);
	assign m_tuser  = out_status_q;

	// Checks on the datapath
	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		free_count_q <= CNT_BITS'(NUM_NODES))
		else $error("free count above node pool size");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		op == OP_POP_RD |-> free_count_q != '0)
		else $error("pop from empty free stack");
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		op == OP_EMIT |-> out_free)
		else $error("result overwritten before transfer");
	a_head_after_rem: assert property (@(posedge clk) disable iff (!arst_n)
		op == OP_HEAD_CAP |-> $past(rem_done))
		else $error("bucket head read before remainder ready");

endmodule

// File: rtl/chm_ctrl.sv
// Controller state machine of the chained hash map: sequences the clear
// sweep, remainder, chain walk and command action. Depends on chm_pkg.
module chm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  chm_pkg::dp_stat_t stat,
	output chm_pkg::dp_op_t   op
);
	import chm_pkg::*;

	state_t state_q;
	state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_next;
		end
	end

	// Next state
	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_CLEAR:    if (stat.clear_last) state_next = ST_IDLE;
			ST_IDLE:     if (s_tvalid) state_next = ST_DIV;
			ST_DIV:      if (stat.rem_done) state_next = ST_HEAD_RD;
			ST_HEAD_RD:  state_next = ST_HEAD_CAP;
			ST_HEAD_CAP: state_next = ST_CHECK;
			ST_CHECK:    state_next = stat.chain_end ? ST_ACT : ST_NODE;
			ST_NODE:     state_next = stat.key_match ? ST_ACT : ST_CHECK;
			ST_ACT: begin
				if (stat.command == CMD_INSERT && !stat.found && !stat.full) begin
					state_next = ST_POP;
				end else begin
					state_next = ST_RESULT;
				end
			end
			ST_POP:      state_next = ST_RESULT;
			ST_RESULT:   if (stat.out_free) state_next = ST_IDLE;
			default:     state_next = ST_IDLE;
		endcase
	end

	// Datapath operation
	always_comb begin
		op = OP_NONE;
		case (state_q)
			ST_CLEAR:    op = OP_CLEAR;
			ST_IDLE:     if (s_tvalid) op = OP_LOAD;
			ST_HEAD_CAP: op = OP_HEAD_CAP;
			ST_NODE:     op = stat.key_match ? OP_NODE_HIT : OP_NODE_STEP;
			ST_ACT: begin
				case (stat.command)
					CMD_INSERT: begin
						if (stat.found) begin
							op = OP_UPDATE;
						end else if (stat.full) begin
							op = OP_FULL;
						end else begin
							op = OP_POP_RD;
						end
					end
					CMD_FIND:  op = stat.found ? OP_FIND : OP_MISS;
					CMD_ERASE: op = stat.found ? OP_ERASE : OP_MISS;
					default:   op = OP_MISS;
				endcase
			end
			ST_POP:      op = OP_LINK_NEW;
			ST_RESULT:   if (stat.out_free) op = OP_EMIT;
			default:     op = OP_NONE;
		endcase
	end

	assign s_tready = (state_q == ST_IDLE);

	// Sequencing checks
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second command taken while one is in progress");
	a_walk_from_head: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_HEAD_CAP |=> state_q == ST_CHECK)
		else $error("chain walk not started from bucket head");
	a_pop_then_link: assert property (@(posedge clk) disable iff (!arst_n)
		op == OP_POP_RD |=> op == OP_LINK_NEW)
		else $error("popped node not linked");

endmodule

// File: rtl/chained_hash_map.sv
// Top level of the chained hash map: controller plus datapath.
// Depends on chm_pkg, chm_ctrl, chm_datapath (and through it chm_ram, chm_rem).
//
//  channel   dir  handshake           payload
//  s_*       in   s_tvalid/s_tready   tdata {value_in, key}, tuser command
//  m_*       out  m_tvalid/m_tready   tdata value_out, tuser status
//  cfg_*     in   cfg_valid/cfg_ready cfg_data number of buckets in use
//
// One command at a time. From transfer to m_tvalid the command passes through
// ST_DIV, ST_HEAD_RD and ST_HEAD_CAP, then ST_CHECK and ST_NODE for each chain
// node (registered node read), then ST_ACT, ST_POP for a new insert only, and
// ST_RESULT. The remainder unit takes 8 steps plus a hand-over in ST_DIV.
// After reset a sweep of all 1024 buckets clears the bucket heads and fills
// the free stack; s_tready stays low meanwhile, cfg writes are taken throughout.
// A held result in the output register stalls only the next result.
module chained_hash_map (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// [30:0] key, [94:31] value_in, [95] zero
	input  logic [chm_pkg::S_DATA_W-1:0]  s_tdata,
	// [1:0] command
	input  logic [chm_pkg::CMD_BITS-1:0]  s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [63:0] value_out
	output logic [chm_pkg::M_DATA_W-1:0]  m_tdata,
	// [1:0] status
	output logic [chm_pkg::STAT_BITS-1:0] m_tuser,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [chm_pkg::BC_BITS-1:0]   cfg_data
);
	import chm_pkg::*;

	dp_op_t   op;
	dp_stat_t stat;

	chm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.op       (op)
	);

	chm_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op),
		.stat      (stat),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

endmodule

// File: test/tb.sv
// Self-checking testbench for chained_hash_map: drives insert, find and erase
// commands, predicts each result with a table model of its own and checks it.
// Depends on chm_pkg and the chained_hash_map RTL.
module tb;
	import chm_pkg::*;

	typedef struct {
		res_t        status;
		logic [63:0] value;
	} outcome_t;

	localparam int QUIET_LIMIT = 20000;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [S_DATA_W-1:0]   s_tdata;   // [30:0] key, [94:31] value_in, [95] zero
	logic [CMD_BITS-1:0]   s_tuser;   // [1:0] command
	logic                  m_tvalid;
	logic                  m_tready;
	logic [M_DATA_W-1:0]   m_tdata;   // [63:0] value_out
	logic [STAT_BITS-1:0]  m_tuser;   // [1:0] status
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [BC_BITS-1:0]    cfg_data;

	// Shadow table
	int unsigned head_of[NUM_BUCKETS];
	logic [30:0] key_of[NUM_NODES];
	logic [63:0] value_of[NUM_NODES];
	int unsigned link_of[NUM_NODES];
	int unsigned free_nodes[NUM_NODES];
	int unsigned free_total;
	int unsigned buckets_used;

	outcome_t    pending_results[$];
	logic [30:0] key_pool[$];
	int          errors = 0;
	int          quiet_cycles = 0;
	int          stall_request = 0;
	bit          idling_on = 1'b1;

	chained_hash_map dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	// Table model: one command, one outcome
	function automatic outcome_t table_apply(input logic [1:0] cmd, input logic [30:0] key,
			input logic [63:0] val);
		outcome_t    res;
		int unsigned n, b, cur, trail, hit, prev_hit, steps, node;
		n = buckets_used;
		if (n == 0) n = 1;
		if (n > NUM_BUCKETS) n = NUM_BUCKETS;
		b = key % n;
		cur = head_of[b];
		trail = NUM_NODES;
		hit = NUM_NODES;
		prev_hit = NUM_NODES;
		steps = 0;
		while (cur < NUM_NODES && steps < NUM_NODES && hit == NUM_NODES) begin
			if (key_of[cur] == key) begin
				hit = cur;
				prev_hit = trail;
			end else begin
				trail = cur;
				cur = link_of[cur];
				steps++;
			end
		end
		res.status = RES_MISS;
		res.value = '0;
		if (cmd == CMD_INSERT) begin
			if (hit < NUM_NODES) begin
				value_of[hit] = val;
				res.status = RES_HIT;
			end else if (free_total == 0) begin
				res.status = RES_FULL;
			end else begin
				free_total--;
				node = free_nodes[free_total];
				key_of[node] = key;
				value_of[node] = val;
				link_of[node] = head_of[b];
				head_of[b] = node;
				res.status = RES_NEW;
			end
		end else if (cmd == CMD_FIND) begin
			if (hit < NUM_NODES) begin
				res.value = value_of[hit];
				res.status = RES_HIT;
			end
		end else if (cmd == CMD_ERASE) begin
			if (hit < NUM_NODES) begin
				if (prev_hit < NUM_NODES) link_of[prev_hit] = link_of[hit];
				else head_of[b] = link_of[hit];
				free_nodes[free_total] = hit;
				free_total++;
				res.status = RES_HIT;
			end
		end
		return res;
	endfunction

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		errors++;
		if (errors <= 50)
			$display("tb: mismatch %s got %h expected %h", what, got, want);
	endtask

	// One command transfer; the outcome is predicted once it is accepted
	task automatic send_command(input logic [1:0] cmd, input logic [30:0] key,
			input logic [63:0] val);
		int gap;
		gap = idling_on ? $urandom_range(0, 4) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {1'b0, val, key};
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(table_apply(cmd, key, val));
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_buckets(input logic [BC_BITS-1:0] count);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= count;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		buckets_used = count;
	endtask

	function automatic logic [30:0] pick_key();
		if (key_pool.size() != 0 && $urandom_range(0, 9) != 0)
			return key_pool[$urandom_range(0, key_pool.size() - 1)];
		return 31'($urandom);
	endfunction

	task automatic run_random(input int count);
		int          r;
		logic [1:0]  cmd;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 45) cmd = CMD_INSERT;
			else if (r < 75) cmd = CMD_FIND;
			else if (r < 95) cmd = CMD_ERASE;
			else cmd = 2'd3;
			send_command(cmd, pick_key(), {$urandom, $urandom});
		end
	endtask

	task automatic fresh_pool(input int count, input logic [30:0] span);
		key_pool.delete();
		for (int i = 0; i < count; i++)
			key_pool.push_back(31'($urandom_range(0, span)));
	endtask

	// Extremes, every command, collisions, erase of head and middle
	task automatic test_directed();
		send_command(CMD_INSERT, 31'd0, 64'd0);
		send_command(CMD_INSERT, 31'h7fffffff, '1);
		send_command(CMD_FIND, 31'd0, '1);
		send_command(CMD_FIND, 31'h7fffffff, '0);
		send_command(CMD_INSERT, 31'd0, 64'h5555_5555_aaaa_aaaa);
		send_command(CMD_FIND, 31'd0, '0);
		send_command(CMD_FIND, 31'd12345, '0);
		send_command(CMD_ERASE, 31'd12345, '0);
		send_command(CMD_ERASE, 31'h7fffffff, '0);
		send_command(CMD_FIND, 31'h7fffffff, '0);
		send_command(2'd3, 31'd0, '1);
		send_command(CMD_FIND, 31'd0, '0);
		// three keys sharing bucket 5
		send_command(CMD_INSERT, 31'd5, 64'h1);
		send_command(CMD_INSERT, 31'd1029, 64'h2);
		send_command(CMD_INSERT, 31'd2053, 64'h3);
		send_command(CMD_ERASE, 31'd1029, '0);
		send_command(CMD_FIND, 31'd5, '0);
		send_command(CMD_FIND, 31'd2053, '0);
		send_command(CMD_ERASE, 31'd2053, '0);
		send_command(CMD_FIND, 31'd5, '0);
		send_command(CMD_FIND, 31'd1029, '0);
	endtask

	task automatic test_one_bucket();
		write_buckets(11'd1);
		fresh_pool(20, 31'h7fffffff);
		run_random(100);
	endtask

	task automatic test_zero_buckets();
		write_buckets(11'd0);
		idling_on = 1'b0;
		run_random(100);
		idling_on = 1'b1;
	endtask

	task automatic test_few_buckets();
		write_buckets(11'd7);
		fresh_pool(24, 31'd200);
		run_random(100);
	endtask

	// Receiver holds off for a long stretch while commands keep coming
	task automatic test_backpressure();
		write_buckets(11'd1024);
		idling_on = 1'b0;
		stall_request = 300;
		run_random(20);
		drain();
		idling_on = 1'b1;
		run_random(20);
	endtask

	// Oversized count clamps; exhaust the node pool, then free some again
	task automatic test_fill_table();
		logic [30:0] k;
		write_buckets(11'd2047);
		key_pool.delete();
		for (int i = 0; i < NUM_NODES + 16; i++) begin
			k = 31'($urandom);
			key_pool.push_back(k);
			send_command(CMD_INSERT, k, {$urandom, $urandom});
		end
		run_random(100);
	endtask

	// Result checker
	always @(posedge clk) begin
		outcome_t want;
		if (m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				report("unexpected result", m_tdata, '0);
			end else begin
				want = pending_results.pop_front();
				if (m_tuser !== want.status) report("status", m_tuser, want.status);
				if (m_tdata[63:0] !== want.value) report("value_out", m_tdata, want.value);
			end
		end
	end

	// Receiver: random waits, and a long hold-off when asked
	initial begin
		int w;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			w = idling_on ? $urandom_range(0, 4) : 0;
			if (stall_request > 0) begin
				m_tready <= 1'b0;
				repeat (stall_request) @(posedge clk);
				stall_request = 0;
			end
			if (w > 0) begin
				m_tready <= 1'b0;
				repeat (w) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// Watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		for (int i = 0; i < NUM_BUCKETS; i++) head_of[i] = NUM_NODES;
		for (int i = 0; i < NUM_NODES; i++) begin
			key_of[i] = '0;
			value_of[i] = '0;
			link_of[i] = NUM_NODES;
			free_nodes[i] = NUM_NODES - 1 - i;
		end
		free_total = NUM_NODES;
		buckets_used = 1024;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_one_bucket();
		test_zero_buckets();
		test_few_buckets();
		test_backpressure();
		test_fill_table();

		drain();
		if (errors == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end
endmodule

// File: files.f
rtl/chm_pkg.sv
rtl/chm_ram.sv
rtl/chm_rem.sv
rtl/chm_datapath.sv
rtl/chm_ctrl.sv
rtl/chained_hash_map.sv
test/tb.sv
